### rtl/otdp_pkg.sv
// shared constants for the odd trial division prime test core
`default_nettype none

package otdp_pkg;

  // width of the candidate on the input port
  localparam int CandW = 32;
  // number of candidate bits that take part in the test
  localparam int Width = 32;
  // bits of the floor square root, and the candidate padded to an even width
  localparam int Half = (Width + 1) / 2;
  localparam int Pad = 2 * Half;
  // bit counter width, the square root remainder and the divider remainder
  localparam int CntW = $clog2(Width);
  localparam int RemW = Half + 2;
  localparam int DivW = Half + 1;
  // result item width, padded to whole bytes
  localparam int OutW = 8;
  // first odd divisor tried
  localparam logic [DivW-1:0] FirstDiv = DivW'(3);

endpackage

`default_nettype wire

### rtl/odd_trial_division_prime_test_core.sv
// odd trial division prime test: bit-serial floor square root, then bit-serial divisions
//
//   channel | dir | tdata fields (low bit up)           | tuser
//   s_      | in  | candidate[31:0]                      | none
//   m_      | out | is_prime, not_odd, zero pad to 8 bits | none
//
// an even candidate or a candidate of one goes from IDLE straight to FIN for its result
// an odd candidate goes first through the 2-bit-per-cycle square root (state ROOT),
// then through the 1-bit-per-cycle divider (state DIV) once for each odd divisor tried
// the worst case is set by the divider loop; one item at a time
// a new item is taken while a finished result waits on the output register
// rst is synchronous; it clears the sequencer and the output valid, nothing else
`default_nettype none

module odd_trial_division_prime_test_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [otdp_pkg::CandW-1:0]  s_tdata,   // candidate
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [otdp_pkg::OutW-1:0]   m_tdata    // is_prime, not_odd, zero pad
);

  typedef enum logic [1:0] {
    IDLE,
    ROOT,
    DIV,
    FIN
  } state_t;

  state_t                          state;
  logic [otdp_pkg::Width-1:0]      n;
  logic [otdp_pkg::Pad-1:0]        sh;
  logic [otdp_pkg::CntW-1:0]       cnt;
  logic [otdp_pkg::Half-1:0]       root;
  logic [otdp_pkg::RemW-1:0]       rem;
  logic [otdp_pkg::DivW-1:0]       d;
  logic [otdp_pkg::DivW-1:0]       drem;
  logic                            res_prime;
  logic                            res_not_odd;

  logic [otdp_pkg::Width-1:0]      n_in;
  logic [otdp_pkg::RemW-1:0]       rem_sh;
  logic [otdp_pkg::RemW-1:0]       trial;
  logic                            root_ge;
  logic [otdp_pkg::Half-1:0]       root_next;
  logic [otdp_pkg::RemW-1:0]       rem_next;
  logic [otdp_pkg::DivW-1:0]       drem_sh;
  logic                            div_ge;
  logic [otdp_pkg::DivW-1:0]       drem_next;
  logic [otdp_pkg::DivW-1:0]       d_plus;
  logic                            out_free;

  // candidate bits under test
  assign n_in = otdp_pkg::Width'(s_tdata);

  assign s_tready = (state == IDLE);
  assign out_free = !m_tvalid || m_tready;

  // square root step: two candidate bits per cycle
  always_comb begin
    rem_sh = {rem[otdp_pkg::RemW-3:0], sh[otdp_pkg::Pad-1 -: 2]};
    trial  = {root, 2'b01};
    root_ge = (rem_sh >= trial);
    if (root_ge) begin
      rem_next  = rem_sh - trial;
      root_next = {root[otdp_pkg::Half-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root[otdp_pkg::Half-2:0], 1'b0};
    end
  end

  // restoring division step: one candidate bit per cycle
  always_comb begin
    drem_sh = {drem[otdp_pkg::DivW-2:0], sh[otdp_pkg::Width-1]};
    div_ge  = (drem_sh >= d);
    drem_next = div_ge ? (drem_sh - d) : drem_sh;
    d_plus  = d + otdp_pkg::DivW'(2);
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // in FIN the output valid is set below whenever it could be cleared here
      if (m_tvalid && m_tready && (state != FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            n <= n_in;
            if (!n_in[0]) begin
              res_prime   <= 1'b0;
              res_not_odd <= 1'b1;
              state       <= FIN;
            end else if (n_in == otdp_pkg::Width'(1)) begin
              res_prime   <= 1'b0;
              res_not_odd <= 1'b0;
              state       <= FIN;
            end else begin
              sh    <= otdp_pkg::Pad'(n_in);
              rem   <= '0;
              root  <= '0;
              cnt   <= otdp_pkg::CntW'(otdp_pkg::Half - 1);
              state <= ROOT;
            end
          end
        end
        ROOT: begin
          rem  <= rem_next;
          root <= root_next;
          if (cnt == '0) begin
            res_not_odd <= 1'b0;
            if (otdp_pkg::FirstDiv > {1'b0, root_next}) begin
              res_prime <= 1'b1;
              state     <= FIN;
            end else begin
              d     <= otdp_pkg::FirstDiv;
              drem  <= '0;
              sh    <= otdp_pkg::Pad'(n);
              cnt   <= otdp_pkg::CntW'(otdp_pkg::Width - 1);
              state <= DIV;
            end
          end else begin
            sh  <= sh << 2;
            cnt <= cnt - 1'b1;
          end
        end
        DIV: begin
          if (cnt == '0) begin
            if (drem_next == '0) begin
              res_prime <= 1'b0;
              state     <= FIN;
            end else if (d_plus > {1'b0, root}) begin
              res_prime <= 1'b1;
              state     <= FIN;
            end else begin
              d    <= d_plus;
              drem <= '0;
              sh   <= otdp_pkg::Pad'(n);
              cnt  <= otdp_pkg::CntW'(otdp_pkg::Width - 1);
            end
          end else begin
            sh   <= sh << 1;
            drem <= drem_next;
            cnt  <= cnt - 1'b1;
          end
        end
        FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(otdp_pkg::OutW - 2){1'b0}}, res_not_odd, res_prime};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // an even candidate is never reported prime
  a_even_not_prime: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("even candidate reported prime");

  // trial divisors stay odd
  a_div_odd: assert property (@(posedge clk) disable iff (rst)
    (state == DIV) |-> d[0])
    else $error("even trial divisor");

  // trial divisors start at three
  a_div_min: assert property (@(posedge clk) disable iff (rst)
    (state == DIV) |-> (d >= otdp_pkg::FirstDiv))
    else $error("trial divisor below three");

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != IDLE))
    else $error("accepted item dropped");
`endif

endmodule

`default_nettype wire

### test/prime_result_checker.sv
// checker for the prime test core: predicts each verdict and compares it with the output stream
`timescale 1ns / 1ps

module prime_result_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic                        s_tready,
  input  wire logic [otdp_pkg::CandW-1:0]  s_tdata,   // candidate
  input  wire logic                        m_tvalid,
  input  wire logic                        m_tready,
  input  wire logic [otdp_pkg::OutW-1:0]   m_tdata,   // is_prime, not_odd, zero pad
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    logic is_prime;
    logic not_odd;
  } verdict_t;

  verdict_t expected_verdicts[$];
  int       mismatches = 0;
  int       waiting = 0;

  assign fail_count = mismatches;
  assign pending = waiting;

  // verdict for one candidate: odd divisors are tried while their square stays within it
  function automatic verdict_t primality_of(logic [otdp_pkg::CandW-1:0] cand);
    logic [63:0] n;
    logic [63:0] d;
    verdict_t    v;
    n = 64'(cand[otdp_pkg::Width-1:0]);
    v.not_odd = ~n[0];
    v.is_prime = n[0] && (n != 64'd1);
    for (d = 64'd3; v.is_prime && (d * d <= n); d += 64'd2) begin
      if (n % d == 64'd0) v.is_prime = 1'b0;
    end
    return v;
  endfunction

  // compare each result with the oldest prediction, then record the newly accepted item
  always @(posedge clk) begin
    verdict_t want;
    int       errs;
    errs = 0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no item pending: tdata %h", m_tdata);
          errs++;
        end else begin
          want = expected_verdicts.pop_front();
          if (m_tdata[0] !== want.is_prime) begin
            $error("is_prime: expected %0b, actual %0b", want.is_prime, m_tdata[0]);
            errs++;
          end
          if (m_tdata[1] !== want.not_odd) begin
            $error("not_odd: expected %0b, actual %0b", want.not_odd, m_tdata[1]);
            errs++;
          end
          if (m_tdata[otdp_pkg::OutW-1:2] !== '0) begin
            $error("pad: expected %0h, actual %0h", 0, m_tdata[otdp_pkg::OutW-1:2]);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) expected_verdicts.push_back(primality_of(s_tdata));
      mismatches <= mismatches + errs;
    end
    waiting <= expected_verdicts.size();
  end

endmodule

### test/tb_top.sv
// testbench top: clock, reset, candidate and backpressure stimulus, final verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 8_000_000;
  localparam int LongHold = 400;
  localparam int DrainCycles = 200;
  localparam int NumCorners = 21;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [otdp_pkg::CandW-1:0] s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [otdp_pkg::OutW-1:0]  m_tdata;
  int                         fail_count;
  int                         pending;
  bit                         tx_idle = 1'b1;
  bit                         rx_idle = 1'b1;
  bit                         hold_req = 1'b0;
  int unsigned                cycle_count = 0;

  // extremes, tiny numbers, odd squares, and a few slow but bounded odd numbers
  logic [otdp_pkg::CandW-1:0] corner_cases [NumCorners] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd7, 32'd8, 32'd9, 32'd15, 32'd25, 32'd49,
    32'd121, 32'd65521, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd16777213, 32'd16752649
  };

  odd_trial_division_prime_test_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  prime_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // offer one candidate, with an optional idle burst first, and wait until it is taken
  task automatic offer(input logic [otdp_pkg::CandW-1:0] cand);
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= otdp_pkg::CandW'($urandom);
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= cand;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait until every predicted verdict has come out
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // mix of evens, small and mid odd numbers, and large odd numbers with a small factor
  function automatic logic [otdp_pkg::CandW-1:0] random_candidate();
    int unsigned                kind;
    int unsigned                f;
    int unsigned                m;
    logic [otdp_pkg::CandW-1:0] c;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      c = otdp_pkg::CandW'($urandom);
      c[0] = 1'b0;
    end else if (kind < 6) begin
      c = otdp_pkg::CandW'($urandom_range(0, 2047) * 2 + 1);
    end else if (kind < 8) begin
      c = otdp_pkg::CandW'($urandom_range(0, 32'h7_FFFF) * 2 + 1);
    end else begin
      // factor bounds the number of trial divisions on a large candidate
      f = $urandom_range(1, 100) * 2 + 1;
      m = $urandom_range(0, (32'hFFFF_FFFF / f - 1) / 2) * 2 + 1;
      c = otdp_pkg::CandW'(f * m);
    end
    return c;
  endfunction

  // receiver: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run guard
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("odd_trial_division_prime_test_core regression: fail");
    $finish;
  end

  // stimulus phases and verdict
  initial begin
    int k;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // corner cases
    for (k = 0; k < NumCorners; k++) offer(corner_cases[k]);
    wait_idle();

    // long receiver hold while quick items pile up behind it
    hold_req = 1'b1;
    for (k = 0; k < 8; k++) begin
      offer(k[0] ? otdp_pkg::CandW'(1)
                 : (otdp_pkg::CandW'($urandom) & ~otdp_pkg::CandW'(1)));
    end
    wait_idle();

    // random items with idling on both sides
    for (k = 0; k < 40; k++) offer(random_candidate());
    wait_idle();

    // random items at full rate
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (k = 0; k < 30; k++) offer(random_candidate());
    wait_idle();
    repeat (DrainCycles) @(negedge clk);

    if (fail_count == 0)
      $display("odd_trial_division_prime_test_core regression: pass");
    else
      $display("odd_trial_division_prime_test_core regression: fail");
    $finish;
  end

endmodule

### files.f
rtl/otdp_pkg.sv
rtl/odd_trial_division_prime_test_core.sv
test/prime_result_checker.sv
test/tb_top.sv
